/* sv/lssh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lssh_pkg;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_CHAR  = 3'd1,
    CMD_EOL   = 3'd2,
    CMD_NEXT  = 3'd3,
    CMD_PREV  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_QUERY_LOW  = 2'd0,
    REG_QUERY_HIGH = 2'd1,
    REG_QUERY_LEN  = 2'd2,
    REG_CASE       = 2'd3
  } reg_idx_t;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_HIT      = 2'd1;
  localparam logic [1:0] ST_NO_HITS  = 2'd2;

  localparam int QUERY_BYTES = 16;
  localparam int LINE_W      = 16;
  localparam int COL_W       = 10;
  localparam int LEN_W       = 5;
  localparam int ENTRY_W     = LINE_W + COL_W;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // fold A-Z to a-z when compare is not exact
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/line_substring_search_hits.sv */
`timescale 1ns / 1ps
`default_nettype none
// an accepted request's result is loaded into the output register at the next clock edge
// throughput: one request per cycle if not stalled; one window compare, one hit table port
// hit table reads are registered in the same edge that loads the result register
// reset: synchronous, clears counters, cursor, window and configuration registers
// hit table contents are not cleared and are only read below the hit count

module line_substring_search_hits
  import lssh_pkg::*;
#(
  parameter int QUERY_MAX = 16,
  parameter int HIT_DEPTH = 256,
  parameter int LINE_MAX  = 1024,
  localparam int CNT_W    = $clog2(HIT_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [2:0]        cmd,
  input  wire logic [7:0]        ch,

  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic [1:0]             status,
  output logic [LINE_W-1:0]      hit_line,
  output logic [COL_W-1:0]       hit_col,
  output logic [LEN_W-1:0]       hit_len,
  output logic [CNT_W-1:0]       hit_total,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  localparam int WIN    = (QUERY_MAX < QUERY_BYTES) ? QUERY_MAX : QUERY_BYTES;
  localparam int ADDR_W = (HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1;
  localparam int CPOS_W = $clog2(LINE_MAX + 1);
  localparam int LIDX_W = LINE_W + 1;

  // configuration
  logic [63:0]      query_low;
  logic [63:0]      query_high;
  logic [LEN_W-1:0] query_length;
  logic             exact_cmp;

  // search state
  logic [WIN-1:0][7:0] window, window_next, win_shift;
  logic [CNT_W-1:0]    hit_cnt, hit_cnt_next;
  logic [ADDR_W-1:0]   cursor, cursor_next;
  logic [LIDX_W-1:0]   line_index, line_index_next;
  logic [CPOS_W-1:0]   column_pos, column_pos_next;
  logic                line_matched, line_matched_next;

  // hit table
  logic [ENTRY_W-1:0] hit_mem [HIT_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;
  logic               wr_en;

  // result register
  logic [1:0]       status_next;
  logic [LEN_W-1:0] len_next;

  logic               accept;
  logic [LEN_W-1:0]   eff_len;
  logic [127:0]       query;
  logic               take;
  logic               hit;
  logic               full;
  logic [16:0]        col_start;
  logic [ADDR_W-1:0]  cur_base, cur_fwd, cur_back, cur_last;
  logic [7:0]         sel_char;
  logic [7:0]         q_char;

  assign pready    = 1'b1;
  assign req_stall = res_valid && res_stall;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_low      <= '0;
      query_high     <= '0;
      query_length   <= '0;
      exact_cmp      <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[4:3]))
        REG_QUERY_LOW:  query_low      <= pwdata;
        REG_QUERY_HIGH: query_high     <= pwdata;
        REG_QUERY_LEN:  query_length   <= pwdata[LEN_W-1:0];
        REG_CASE:       exact_cmp      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:3]))
      REG_QUERY_LOW:  prdata = query_low;
      REG_QUERY_HIGH: prdata = query_high;
      REG_QUERY_LEN:  prdata = {{(64-LEN_W){1'b0}}, query_length};
      REG_CASE:       prdata = {63'd0, exact_cmp};
      default:        prdata = '0;
    endcase
  end

  assign eff_len = (query_length > LEN_W'(WIN)) ? LEN_W'(WIN) : query_length;
  assign query   = {query_high, query_low};

  // window with the new character in front
  always_comb begin
    win_shift[0] = ch;
    for (int j = 1; j < WIN; j++) begin
      win_shift[j] = window[j-1];
    end
  end

  // query char k lines up with window entry eff_len-1-k
  always_comb begin
    hit = (eff_len != '0) &&
          ((17'(column_pos) + 17'd1) >= 17'(eff_len));
    for (int k = 0; k < WIN; k++) begin
      sel_char = '0;
      for (int j = 0; j < WIN; j++) begin
        if (j + k + 1 == int'(eff_len)) begin
          sel_char = win_shift[j];
        end
      end
      q_char = query[8*k +: 8];
      if (k < int'(eff_len) &&
          fold_char(sel_char, exact_cmp) != fold_char(q_char, exact_cmp)) begin
        hit = 1'b0;
      end
    end
  end

  assign take      = !line_index[LIDX_W-1] && (column_pos < CPOS_W'(LINE_MAX));
  assign full      = (hit_cnt == CNT_W'(HIT_DEPTH));
  assign col_start = 17'(column_pos) + 17'd1 - 17'(eff_len);
  assign wr_data   = {line_index[LINE_W-1:0], col_start[COL_W-1:0]};

  assign cur_base = (CNT_W'(cursor) >= hit_cnt) ? '0 : cursor;
  assign cur_last = ADDR_W'(hit_cnt - CNT_W'(1));
  assign cur_fwd  = ((CNT_W'(cur_base) + CNT_W'(1)) == hit_cnt) ? '0
                                                                 : cur_base + ADDR_W'(1);
  assign cur_back = (cur_base == '0) ? cur_last : cur_base - ADDR_W'(1);

  always_comb begin
    window_next       = window;
    hit_cnt_next      = hit_cnt;
    cursor_next       = cursor;
    line_index_next   = line_index;
    column_pos_next   = column_pos;
    line_matched_next = line_matched;
    status_next       = ST_ACCEPTED;
    len_next          = '0;
    wr_en             = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = cur_base;
    if (accept) begin
      case (cmd_t'(cmd))
        CMD_START: begin
          hit_cnt_next      = '0;
          cursor_next       = '0;
          line_index_next   = '0;
          window_next       = '0;
          column_pos_next   = '0;
          line_matched_next = 1'b0;
        end
        CMD_CHAR: begin
          if (take) begin
            window_next     = win_shift;
            column_pos_next = column_pos + CPOS_W'(1);
            if (hit && !line_matched && !full) begin
              wr_en             = 1'b1;
              hit_cnt_next      = hit_cnt + CNT_W'(1);
              line_matched_next = 1'b1;
            end
          end
        end
        CMD_EOL: begin
          if (!line_index[LIDX_W-1]) begin
            line_index_next = line_index + LIDX_W'(1);
          end
          window_next       = '0;
          column_pos_next   = '0;
          line_matched_next = 1'b0;
        end
        CMD_NEXT: begin
          if (hit_cnt == '0) begin
            status_next = ST_NO_HITS;
          end else begin
            status_next = ST_HIT;
            len_next    = eff_len;
            rd_en       = 1'b1;
            rd_addr     = cur_base;
            cursor_next = cur_fwd;
          end
        end
        CMD_PREV: begin
          if (hit_cnt == '0) begin
            status_next = ST_NO_HITS;
          end else begin
            status_next = ST_HIT;
            len_next    = eff_len;
            rd_en       = 1'b1;
            rd_addr     = cur_back;
            cursor_next = cur_back;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      hit_cnt      <= '0;
      cursor       <= '0;
      line_index   <= '0;
      column_pos   <= '0;
      line_matched <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      window       <= window_next;
      hit_cnt      <= hit_cnt_next;
      cursor       <= cursor_next;
      line_index   <= line_index_next;
      column_pos   <= column_pos_next;
      line_matched <= line_matched_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      hit_len   <= len_next;
      hit_total <= hit_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hit_mem[ADDR_W'(hit_cnt)] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= hit_mem[rd_addr];
    end
  end

  assign hit_line = (status == ST_HIT) ? rd_data[ENTRY_W-1:COL_W] : '0;
  assign hit_col  = (status == ST_HIT) ? rd_data[COL_W-1:0] : '0;

endmodule

`default_nettype wire
